### src/kbr_pkg.sv
// Shared types, constants and key tables for the keyboard boot report block.
// No dependencies; every other file imports this package.
package kbr_pkg;

    // Number of held-key slots kept in state, and slots carried in a report
    localparam int SLOT_COUNT   = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int PAD_SLOTS    = (SLOT_COUNT > REPORT_SLOTS) ? SLOT_COUNT : REPORT_SLOTS;

    // Event class acted on
    localparam logic [4:0] EV_KEY_CLASS = 5'd1;

    // Release code of key_value; every other value is a press
    localparam logic [1:0] KEY_RELEASE = 2'd0;

    // Empty slot marker
    localparam logic [7:0] USAGE_NONE = 8'h00;

    typedef logic [7:0] usage_t;
    typedef logic [SLOT_COUNT-1:0][7:0] slot_vec_t;
    typedef logic [PAD_SLOTS-1:0][7:0]  pad_vec_t;

    // Input request
    typedef struct packed {
        logic [4:0] event_type;
        logic [9:0] key_code;
        logic [1:0] key_value;
    } ev_req_t;

    // Result report
    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] usage_slot_0;
        logic [7:0] usage_slot_1;
        logic [7:0] usage_slot_2;
        logic [7:0] usage_slot_3;
        logic [7:0] usage_slot_4;
        logic [7:0] usage_slot_5;
    } report_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic   is_mod;
        logic   press;
        logic [7:0] mask;
        usage_t usage;
    } cmd_t;

    // Modifier key code to modifier byte bit
    function automatic logic [7:0] modifier_mask(input logic [9:0] code);
        logic [7:0] m;
        case (code)
            10'd29:  m = 8'h01;  // left ctrl
            10'd42:  m = 8'h02;  // left shift
            10'd56:  m = 8'h04;  // left alt
            10'd125: m = 8'h08;  // left meta
            10'd97:  m = 8'h10;  // right ctrl
            10'd54:  m = 8'h20;  // right shift
            10'd100: m = 8'h40;  // right alt
            10'd126: m = 8'h80;  // right meta
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Key code to HID usage; zero for an unmapped code
    function automatic usage_t usage_lookup(input logic [9:0] code);
        usage_t u;
        case (code[5:0])
            6'd30: u = 8'h04;  6'd48: u = 8'h05;  6'd46: u = 8'h06;
            6'd32: u = 8'h07;  6'd18: u = 8'h08;  6'd33: u = 8'h09;
            6'd34: u = 8'h0A;  6'd35: u = 8'h0B;  6'd23: u = 8'h0C;
            6'd36: u = 8'h0D;  6'd37: u = 8'h0E;  6'd38: u = 8'h0F;
            6'd50: u = 8'h10;  6'd49: u = 8'h11;  6'd24: u = 8'h12;
            6'd25: u = 8'h13;  6'd16: u = 8'h14;  6'd19: u = 8'h15;
            6'd31: u = 8'h16;  6'd20: u = 8'h17;  6'd22: u = 8'h18;
            6'd47: u = 8'h19;  6'd17: u = 8'h1A;  6'd45: u = 8'h1B;
            6'd21: u = 8'h1C;  6'd44: u = 8'h1D;
            6'd2:  u = 8'h1E;  6'd3:  u = 8'h1F;  6'd4:  u = 8'h20;
            6'd5:  u = 8'h21;  6'd6:  u = 8'h22;  6'd7:  u = 8'h23;
            6'd8:  u = 8'h24;  6'd9:  u = 8'h25;  6'd10: u = 8'h26;
            6'd11: u = 8'h27;
            6'd28: u = 8'h28;  6'd1:  u = 8'h29;  6'd14: u = 8'h2A;
            6'd15: u = 8'h2B;  6'd57: u = 8'h2C;
            default: u = USAGE_NONE;
        endcase
        if (code[9:6] != 4'd0) begin
            u = USAGE_NONE;
        end
        return u;
    endfunction

    // Occupied slots form a prefix: no empty slot before a full one
    function automatic logic slots_are_prefix(input slot_vec_t s);
        logic ok;
        ok = 1'b1;
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (s[i-1] == USAGE_NONE && s[i] != USAGE_NONE) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

### src/kbr_front.sv
// Front end: accepts key event requests, classifies them and drops those
// that cause no report. Depends on kbr_pkg.
module kbr_front
    import kbr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  ev_req_t s_payload,
    output logic    cmd_valid,
    output cmd_t    cmd,
    input  logic    cmd_ready
);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] mask;
    usage_t     usage;
    logic       is_key;
    logic       accept;

    // Classification
    assign mask   = modifier_mask(s_payload.key_code);
    assign usage  = usage_lookup(s_payload.key_code);
    assign is_key = (s_payload.event_type == EV_KEY_CLASS);

    assign s_ready = !valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (accept) begin
            valid_next     = is_key && (mask != 8'h00 || usage != USAGE_NONE);
            cmd_next.is_mod = (mask != 8'h00);
            cmd_next.press  = (s_payload.key_value != KEY_RELEASE);
            cmd_next.mask   = mask;
            cmd_next.usage  = usage;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### src/kbr_queue.sv
// Two-entry command queue between front and back ends.
// Depends on kbr_pkg.
module kbr_queue
    import kbr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### src/kbr_back.sv
// Back end: applies commands to the held modifier byte and usage list and
// registers one report per command. Depends on kbr_pkg.
module kbr_back
    import kbr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output report_t   m_payload,
    output slot_vec_t held_usages
);

    logic [7:0] held_mods_reg, held_mods_next;
    slot_vec_t  held_reg, held_next;
    slot_vec_t  added, removed, shifted;
    pad_vec_t   padded;
    logic       out_valid_reg, out_valid_next;
    report_t    out_reg, out_next;
    logic       take;
    logic       present, prev_full, hit;

    assign cmd_ready = !out_valid_reg || m_ready;
    assign take      = cmd_valid && cmd_ready;
    assign shifted   = slot_vec_t'(held_reg >> 8);

    // Press: append to the first empty slot unless already held
    always_comb begin
        present = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            present |= (held_reg[i] == cmd.usage);
        end
        prev_full = 1'b1;
        added     = held_reg;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!present && prev_full && held_reg[i] == USAGE_NONE) begin
                added[i] = cmd.usage;
            end
            prev_full = (held_reg[i] != USAGE_NONE);
        end
    end

    // Release: drop the matching slot and close the gap
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit |= (held_reg[i] == cmd.usage);
            removed[i] = hit ? shifted[i] : held_reg[i];
        end
    end

    // Next state and report
    always_comb begin
        held_next      = held_reg;
        held_mods_next = held_mods_reg;
        if (cmd.is_mod) begin
            held_mods_next = cmd.press ? (held_mods_reg | cmd.mask)
                                       : (held_mods_reg & ~cmd.mask);
        end else begin
            held_next = cmd.press ? added : removed;
        end
        padded                 = pad_vec_t'(held_next);
        out_next.modifier_bits = held_mods_next;
        out_next.usage_slot_0  = padded[0];
        out_next.usage_slot_1  = padded[1];
        out_next.usage_slot_2  = padded[2];
        out_next.usage_slot_3  = padded[3];
        out_next.usage_slot_4  = padded[4];
        out_next.usage_slot_5  = padded[5];
        out_valid_next = take ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            held_mods_reg <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                held_reg      <= held_next;
                held_mods_reg <= held_mods_next;
            end
        end
        if (take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_payload   = out_reg;
    assign held_usages = held_reg;

endmodule

### src/keyboard_event_to_boot_report.sv
// Top level: key event requests in, boot keyboard reports out.
// Depends on kbr_pkg, kbr_front, kbr_queue and kbr_back.
//
//  Channel  Dir  Payload    Handshake
//  s_       in   ev_req_t   s_valid / s_ready
//  m_       out  report_t   m_valid / m_ready
//
// One request per cycle sustained while m_ready holds; a reporting request
// is offered on m_ after the front register, queue and output register.
// Synchronous active-low reset empties the pipeline and clears held state.
// A stalled m_ side fills the output register, the two-entry queue and the
// front register before s_ready drops; requests causing no report leave the
// front stage silently.
module keyboard_event_to_boot_report
    import kbr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  ev_req_t s_payload,
    output logic    m_valid,
    input  logic    m_ready,
    output report_t m_payload
);

    logic      f_valid, f_ready;
    cmd_t      f_cmd;
    logic      q_valid, q_ready;
    cmd_t      q_cmd;
    slot_vec_t held_usages;

    // Classification
    kbr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    // Decoupling queue
    kbr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // State update and report
    kbr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .held_usages (held_usages)
    );

    // Non-key requests never reach the queue
    a_drop_non_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.event_type != EV_KEY_CLASS |=> !f_valid)
        else $error("non-key request produced a command");

    // Back pressure only while the front stage holds a command
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> f_valid && !f_ready)
        else $error("input stalled without a blocked command");

    // Held usages always form a prefix of the slot list
    a_slot_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        slots_are_prefix(held_usages))
        else $error("gap in held usage list");

endmodule

### tb/keyboard_event_to_boot_report_tb.sv
// Self-checking bench for keyboard_event_to_boot_report: key event requests in,
// boot keyboard reports checked against a scoreboard predicted in the bench.
// Depends on kbr_pkg and the keyboard_event_to_boot_report top level.
module keyboard_event_to_boot_report_tb;
    import kbr_pkg::*;

    localparam logic [1:0] KEY_PRESS  = 2'd1;
    localparam logic [1:0] KEY_REPEAT = 2'd2;
    localparam logic [1:0] KEY_SPARE  = 2'd3;   // unused value, still a press
    localparam int RANDOM_LIVE_ITEMS = 1000;
    localparam int HOLD_OFF_AFTER    = 300;
    localparam int HOLD_OFF_CYCLES   = 150;
    localparam int DRAIN_CYCLES      = 100;
    localparam int MAX_PRINTED       = 40;
    localparam int REPORT_FIELDS     = 7;
    localparam logic [9:0] MOD_KEY_CODES [8] = '{10'd29, 10'd42, 10'd56, 10'd125,
                                                 10'd97, 10'd54, 10'd100, 10'd126};

    logic    aclk;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    ev_req_t s_payload = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    report_t m_payload;

    keyboard_event_to_boot_report dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Requests waiting to be offered, and reports the predictor says are due
    ev_req_t key_events[$];
    report_t due_reports[$];

    // Predicted keyboard state
    logic [7:0] held_mods = 8'h00;
    usage_t     held_keys[SLOT_COUNT] = '{default: USAGE_NONE};

    int    accepted_count = 0;
    int    total_items    = 0;
    int    noise_items    = 0;
    int    report_count   = 0;
    int    error_count    = 0;
    int    send_gap       = 0;
    int    send_calm      = 0;
    int    recv_stall     = 0;
    int    recv_calm      = 0;
    logic  hold_off       = 1'b0;
    report_t want_report;
    report_t seen_report;
    string field_names[REPORT_FIELDS] = '{"modifier_bits", "usage_slot_0", "usage_slot_1",
                                          "usage_slot_2", "usage_slot_3", "usage_slot_4",
                                          "usage_slot_5"};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Modifier key code to its bit in the modifier byte
    function automatic logic [7:0] modifier_bit_of(input logic [9:0] code);
        case (code)
            10'd29:  return 8'h01;  // left ctrl
            10'd42:  return 8'h02;  // left shift
            10'd56:  return 8'h04;  // left alt
            10'd125: return 8'h08;  // left meta
            10'd97:  return 8'h10;  // right ctrl
            10'd54:  return 8'h20;  // right shift
            10'd100: return 8'h40;  // right alt
            10'd126: return 8'h80;  // right meta
            default: return 8'h00;
        endcase
    endfunction

    // Key code to HID usage over the full code range; none if unmapped
    function automatic usage_t hid_usage_of(input logic [9:0] code);
        case (code)
            10'd30: return 8'h04;  10'd48: return 8'h05;  10'd46: return 8'h06;
            10'd32: return 8'h07;  10'd18: return 8'h08;  10'd33: return 8'h09;
            10'd34: return 8'h0A;  10'd35: return 8'h0B;  10'd23: return 8'h0C;
            10'd36: return 8'h0D;  10'd37: return 8'h0E;  10'd38: return 8'h0F;
            10'd50: return 8'h10;  10'd49: return 8'h11;  10'd24: return 8'h12;
            10'd25: return 8'h13;  10'd16: return 8'h14;  10'd19: return 8'h15;
            10'd31: return 8'h16;  10'd20: return 8'h17;  10'd22: return 8'h18;
            10'd47: return 8'h19;  10'd17: return 8'h1A;  10'd45: return 8'h1B;
            10'd21: return 8'h1C;  10'd44: return 8'h1D;
            10'd2:  return 8'h1E;  10'd3:  return 8'h1F;  10'd4:  return 8'h20;
            10'd5:  return 8'h21;  10'd6:  return 8'h22;  10'd7:  return 8'h23;
            10'd8:  return 8'h24;  10'd9:  return 8'h25;  10'd10: return 8'h26;
            10'd11: return 8'h27;
            10'd28: return 8'h28;  10'd1:  return 8'h29;  10'd14: return 8'h2A;
            10'd15: return 8'h2B;  10'd57: return 8'h2C;
            default: return USAGE_NONE;
        endcase
    endfunction

    // Update the held state for one accepted request and queue its report
    task automatic apply_key_event(input ev_req_t ev);
        logic [7:0] mask;
        usage_t     usage;
        logic       press;
        logic       placed;
        int         w;
        report_t    rep;
        mask  = modifier_bit_of(ev.key_code);
        usage = hid_usage_of(ev.key_code);
        press = (ev.key_value != KEY_RELEASE);
        if (ev.event_type != EV_KEY_CLASS || (mask == 8'h00 && usage == USAGE_NONE)) begin
            return;
        end
        if (mask != 8'h00) begin
            held_mods = press ? (held_mods | mask) : (held_mods & ~mask);
        end else if (press) begin
            // add if absent and a slot is free; duplicates and overflow leave the list
            placed = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!placed && held_keys[i] == usage) begin
                    placed = 1'b1;
                end else if (!placed && held_keys[i] == USAGE_NONE) begin
                    held_keys[i] = usage;
                    placed = 1'b1;
                end
            end
        end else begin
            // drop the usage and close the gap, keeping press order
            w = 0;
            for (int r = 0; r < SLOT_COUNT; r++) begin
                if (held_keys[r] != USAGE_NONE && held_keys[r] != usage) begin
                    held_keys[w] = held_keys[r];
                    w++;
                end
            end
            for (int i = w; i < SLOT_COUNT; i++) begin
                held_keys[i] = USAGE_NONE;
            end
        end
        rep.modifier_bits = held_mods;
        rep.usage_slot_0  = held_keys[0];
        rep.usage_slot_1  = held_keys[1];
        rep.usage_slot_2  = held_keys[2];
        rep.usage_slot_3  = held_keys[3];
        rep.usage_slot_4  = held_keys[4];
        rep.usage_slot_5  = held_keys[5];
        due_reports = {due_reports, rep};
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Idle length: mostly short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_send_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 60) begin
            send_calm = $urandom_range(20, 80);
            return 0;
        end
        return idle_length();
    endfunction

    task automatic queue_event(input logic [4:0] t, input logic [9:0] c, input logic [1:0] v);
        ev_req_t ev;
        ev.event_type = t;
        ev.key_code   = c;
        ev.key_value  = v;
        key_events = {key_events, ev};
    endtask

    function automatic logic [9:0] random_key_code();
        logic [9:0] c;
        do begin
            c = 10'($urandom_range(1, 57));
        end while (hid_usage_of(c) == USAGE_NONE);
        return c;
    endfunction

    function automatic logic [1:0] press_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return KEY_PRESS;
        end else if (r < 95) begin
            return KEY_REPEAT;
        end
        return KEY_SPARE;
    endfunction

    // A well-formed burst of typing: optional modifier, keys down, keys up in any order
    task automatic queue_typing_burst();
        logic [9:0] keys[$];
        logic [9:0] mod;
        logic [9:0] tmp;
        logic       use_mod;
        int         n;
        int         j;
        int         mod_up_at;
        n       = $urandom_range(1, 8);
        use_mod = 1'($urandom_range(0, 1));
        mod     = MOD_KEY_CODES[$urandom_range(0, 7)];
        if (use_mod) begin
            queue_event(EV_KEY_CLASS, mod, press_value());
        end
        for (int i = 0; i < n; i++) begin
            keys = {keys, random_key_code()};
            queue_event(EV_KEY_CLASS, keys[i], press_value());
            if ($urandom_range(0, 9) == 0) begin
                queue_event(EV_KEY_CLASS, keys[i], KEY_REPEAT);
            end
        end
        for (int i = n - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = keys[i];
            keys[i] = keys[j];
            keys[j] = tmp;
        end
        mod_up_at = $urandom_range(0, n);
        for (int i = 0; i < n; i++) begin
            if (use_mod && i == mod_up_at) begin
                queue_event(EV_KEY_CLASS, mod, KEY_RELEASE);
            end
            queue_event(EV_KEY_CLASS, keys[i], KEY_RELEASE);
        end
        if (use_mod && mod_up_at == n) begin
            queue_event(EV_KEY_CLASS, mod, KEY_RELEASE);
        end
    endtask

    // Noise: arbitrary events, or a stray release of a key that is not down
    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_event(EV_KEY_CLASS, random_key_code(), KEY_RELEASE);
            end else begin
                queue_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                            2'($urandom_range(0, 3)));
                noise_items++;
            end
        end
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_key_event(s_payload);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (key_events.size() > 0) begin
                    s_payload <= key_events.pop_front();
                    s_valid   <= 1'b1;
                    send_gap  = next_send_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_report = m_payload;
                if (due_reports.size() == 0) begin
                    report_mismatch($sformatf("report %0d arrived with none expected",
                                              report_count));
                end else begin
                    want_report = due_reports.pop_front();
                    for (int f = 0; f < REPORT_FIELDS; f++) begin
                        if (seen_report[55 - 8 * f -: 8] !== want_report[55 - 8 * f -: 8]) begin
                            report_mismatch($sformatf("report %0d %s: got %02h expected %02h",
                                report_count, field_names[f], seen_report[55 - 8 * f -: 8],
                                want_report[55 - 8 * f -: 8]));
                        end
                    end
                end
                report_count++;
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(0, 99) < 25) begin
                    recv_stall = idle_length();
                end else if ($urandom_range(0, 99) < 5) begin
                    recv_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and s_ready drops
    initial begin
        while (accepted_count < HOLD_OFF_AFTER) begin
            @(posedge aclk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #8000000;
        $display("[keyboard_event_to_boot_report] ERROR");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        // not key events, unmapped codes, and a high code aliasing a letter
        queue_event(5'd0, 10'd30, KEY_PRESS);
        queue_event(5'd31, 10'd767, KEY_SPARE);
        queue_event(EV_KEY_CLASS, 10'd0, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd767, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd94, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd63, KEY_RELEASE);
        // release of a key not held
        queue_event(EV_KEY_CLASS, 10'd30, KEY_RELEASE);
        // seven presses: the seventh finds every slot taken
        queue_event(EV_KEY_CLASS, 10'd1, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd57, KEY_SPARE);
        queue_event(EV_KEY_CLASS, 10'd2, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd11, KEY_REPEAT);
        queue_event(EV_KEY_CLASS, 10'd28, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd14, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd15, KEY_PRESS);
        // repeat press of a held key, then a release from the middle
        queue_event(EV_KEY_CLASS, 10'd57, KEY_PRESS);
        queue_event(EV_KEY_CLASS, 10'd2, KEY_RELEASE);
        queue_event(EV_KEY_CLASS, 10'd15, KEY_PRESS);
        // every modifier down, then the two meta keys up
        for (int i = 0; i < 8; i++) begin
            queue_event(EV_KEY_CLASS, MOD_KEY_CODES[i], (i % 3 == 0) ? KEY_SPARE : KEY_PRESS);
        end
        queue_event(EV_KEY_CLASS, 10'd125, KEY_RELEASE);
        queue_event(EV_KEY_CLASS, 10'd126, KEY_RELEASE);

        // random part: mostly typing bursts, some noise
        while (key_events.size() - noise_items < RANDOM_LIVE_ITEMS + 20) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_noise();
            end else begin
                queue_typing_burst();
            end
        end
        total_items = key_events.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < total_items) begin
            @(posedge aclk);
        end
        while (due_reports.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[keyboard_event_to_boot_report] OK");
        end else begin
            $display("[keyboard_event_to_boot_report] ERROR");
        end
        $finish;
    end

endmodule
